@@ hw/rtl/rgbsp_pkg.sv @@
`timescale 1ns / 1ps

package rgbsp_pkg;

    // Field widths
    localparam int unsigned PIXEL_W  = 16;
    localparam int unsigned RGBA_W   = 32;
    localparam int unsigned SIDE_W   = 12;
    localparam int unsigned COLUMN_W = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // Largest side the register field can hold
    localparam int unsigned SIDE_FIELD_MAX = 4095;
    localparam int unsigned MAX_SIDE_DEFAULT = 4095;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_FACTOR = 2'd1;

    // Register values after reset
    localparam logic [SIDE_W-1:0] SIDE_RESET  = 12'd64;
    localparam logic [SIDE_W-1:0] SHEAR_RESET = 12'd0;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Status of the shift divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Widen a 5-bit channel to 8 bits and scale by 1.03, rounding down.
    // The divide by 100 is a multiply by 5243 / 2^19, exact over 0..25544.
    function automatic logic [7:0] scale_channel(input logic [4:0] c5);
        logic [14:0] scaled;
        logic [27:0] product;
        begin
            scaled  = 15'({c5, 3'b000}) * 15'd103;
            product = 28'(scaled) * 28'd5243;
            return product[26:19];
        end
    endfunction

endpackage

@@ hw/rtl/rgbsp_shift_div.sv @@
`timescale 1ns / 1ps

module rgbsp_shift_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [rgbsp_pkg::COLUMN_W-1:0]     dividend,
    input  logic [rgbsp_pkg::SIDE_W-1:0]       divisor,
    output rgbsp_pkg::div_status_t             status,
    output logic [rgbsp_pkg::SIDE_W-1:0]       quotient
);
    import rgbsp_pkg::*;

    localparam int unsigned STEPS = COLUMN_W;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic [SIDE_W-1:0]   rem_reg, rem_next;
    logic [COLUMN_W-1:0] quo_reg, quo_next;
    logic [SIDE_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [COLUMN_W-1:0] trial;
    logic                fits;
    logic [COLUMN_W-1:0] trial_sub;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[COLUMN_W-1]};
        fits      = trial >= {1'b0, div_reg};
        trial_sub = trial - {1'b0, div_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_sub[SIDE_W-1:0] : trial[SIDE_W-1:0];
            quo_next = {quo_reg[COLUMN_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    // Quotient never exceeds the side, so the top bit is always clear
    assign quotient    = quo_reg[SIDE_W-1:0];

    property p_done_ends_busy;
        @(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg;
    endproperty
    a_done_ends_busy: assert property (p_done_ends_busy)
        else $error("divider done while still busy");

    property p_start_runs;
        @(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && cnt_reg == CNT_W'(STEPS));
    endproperty
    a_start_runs: assert property (p_start_runs)
        else $error("divider did not load on start");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("divider busy with empty step count");

endmodule

@@ hw/rtl/rgb555_sheared_preview_unpacker_core.sv @@
`timescale 1ns / 1ps

// Converts RGB555 pixels of a square image, row-major, into RGBA8888 words
// (each channel widened to 8 bits and scaled by 1.03, alpha 0xFF) tagged with
// the row, the sheared column and a flag on the last pixel of the frame. One
// pixel is taken per clock and its result appears in the output register in
// the next cycle; a stalled output still lets a pixel in whenever that
// register is being emptied in the same cycle. Writing either register
// restarts the frame: the starting shift ceil(side/shear) comes from a
// bit-serial divider that holds in_ready low after the write while it loads,
// runs its 13 steps and stores the quotient; with shear 0 only the restart
// holds it. Results leave strictly in input order.
module rgb555_sheared_preview_unpacker_core
#(
    parameter int unsigned MAX_SIDE = rgbsp_pkg::MAX_SIDE_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [rgbsp_pkg::PIXEL_W-1:0]      pixel_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rgbsp_pkg::RGBA_W-1:0]       rgba_value,
    output logic [rgbsp_pkg::SIDE_W-1:0]       row_index,
    output logic [rgbsp_pkg::COLUMN_W-1:0]     column_index,
    output logic                               frame_end,
    input  logic                               cfg_write,
    input  logic [rgbsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rgbsp_pkg::*;

    localparam int unsigned CAP_INT = (MAX_SIDE > SIDE_FIELD_MAX) ? SIDE_FIELD_MAX : MAX_SIDE;
    localparam logic [SIDE_W-1:0] SIDE_CAP = SIDE_W'(CAP_INT);

    // Configuration and frame state
    logic [SIDE_W-1:0] side_reg, side_next;
    logic [SIDE_W-1:0] shear_reg, shear_next;
    logic              restart_reg, restart_next;
    logic [SIDE_W-1:0] col_reg, col_next;
    logic [SIDE_W-1:0] row_reg, row_next;
    logic [SIDE_W-1:0] cd_reg, cd_next;
    logic [SIDE_W-1:0] shift_reg, shift_next;
    logic [SIDE_W-1:0] init_shift_reg, init_shift_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [RGBA_W-1:0]   rgba_reg;
    logic [SIDE_W-1:0]   row_out_reg;
    logic [COLUMN_W-1:0] col_out_reg;
    logic                end_out_reg;

    logic [SIDE_W-1:0]   side_eff;
    logic                shear_on;
    logic [SIDE_W-1:0]   cd_reload;
    logic [COLUMN_W-1:0] div_dividend;
    div_status_t         div_status;
    logic [SIDE_W-1:0]   div_quotient;
    logic                div_start;
    logic                busy;
    logic                in_fire;

    logic [SIDE_W-1:0]   cd_dec;
    logic [SIDE_W-1:0]   cd_item;
    logic [SIDE_W-1:0]   shift_item;
    logic [COLUMN_W-1:0] col_sum;
    logic                col_wrap;
    logic                row_wrap;
    logic                last_pixel;
    logic [RGBA_W-1:0]   rgba_item;

    // Effective side: zero reads as one, capped at the maximum
    always_comb
    begin
        side_eff = (side_reg == '0) ? SIDE_W'(1) : side_reg;
        if (side_eff > SIDE_CAP)
        begin
            side_eff = SIDE_CAP;
        end
    end

    assign shear_on     = shear_reg != '0;
    assign cd_reload    = shear_on ? shear_reg : side_eff;
    assign div_dividend = {1'b0, side_eff} + {1'b0, shear_reg} - COLUMN_W'(1);
    assign div_start    = restart_reg && shear_on;

    rgbsp_shift_div u_shift_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (shear_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // Hold requests off while the starting shift is being derived
    assign busy     = restart_reg || div_status.busy || div_status.done;
    assign in_ready = !busy && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // Countdown step at the start of each row, then the column and frame test
    always_comb
    begin
        cd_dec     = cd_reg - SIDE_W'(1);
        cd_item    = cd_reg;
        shift_item = shift_reg;
        if ((col_reg == '0) && shear_on)
        begin
            if (cd_dec == '0)
            begin
                cd_item = shear_reg;
                if (shift_reg != '0)
                begin
                    shift_item = shift_reg - SIDE_W'(1);
                end
            end
            else
            begin
                cd_item = cd_dec;
            end
        end
        col_sum    = {1'b0, col_reg} + {1'b0, shift_item};
        col_wrap   = ({1'b0, col_reg} + COLUMN_W'(1)) >= {1'b0, side_eff};
        row_wrap   = ({1'b0, row_reg} + COLUMN_W'(1)) >= {1'b0, side_eff};
        last_pixel = col_wrap && row_wrap;
        rgba_item  = {scale_channel(pixel_word[14:10]), scale_channel(pixel_word[9:5]),
                      scale_channel(pixel_word[4:0]), ALPHA_OPAQUE};
    end

    // Register writes, frame restart and counter advance
    always_comb
    begin
        side_next       = side_reg;
        shear_next      = shear_reg;
        restart_next    = 1'b0;
        col_next        = col_reg;
        row_next        = row_reg;
        cd_next         = cd_reg;
        shift_next      = shift_reg;
        init_shift_next = init_shift_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_SIDE_LENGTH:
                begin
                    side_next    = cfg_data;
                    restart_next = 1'b1;
                end
                REG_SHEAR_FACTOR:
                begin
                    shear_next   = cfg_data;
                    restart_next = 1'b1;
                end
                default:
                begin
                    restart_next = 1'b0;
                end
            endcase
        end

        if (restart_reg)
        begin
            col_next = '0;
            row_next = '0;
            cd_next  = cd_reload;
            if (!shear_on)
            begin
                shift_next      = '0;
                init_shift_next = '0;
            end
        end
        else if (div_status.done && shear_on)
        begin
            // Store the quotient as the starting shift; one left over from before shearing was switched off is dropped
            shift_next      = div_quotient;
            init_shift_next = div_quotient;
        end
        else if (in_fire)
        begin
            if (last_pixel)
            begin
                col_next   = '0;
                row_next   = '0;
                cd_next    = cd_reload;
                shift_next = init_shift_reg;
            end
            else
            begin
                cd_next    = cd_item;
                shift_next = shift_item;
                if (col_wrap)
                begin
                    col_next = '0;
                    row_next = row_reg + SIDE_W'(1);
                end
                else
                begin
                    col_next = col_reg + SIDE_W'(1);
                end
            end
        end
    end

    // Output register: load on accept, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg       <= SIDE_RESET;
            shear_reg      <= SHEAR_RESET;
            restart_reg    <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            cd_reg         <= SIDE_RESET;
            shift_reg      <= '0;
            init_shift_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            side_reg       <= side_next;
            shear_reg      <= shear_next;
            restart_reg    <= restart_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            cd_reg         <= cd_next;
            shift_reg      <= shift_next;
            init_shift_reg <= init_shift_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rgba_reg    <= rgba_item;
            row_out_reg <= row_reg;
            col_out_reg <= col_sum;
            end_out_reg <= last_pixel;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rgba_value   = rgba_reg;
    assign row_index    = row_out_reg;
    assign column_index = col_out_reg;
    assign frame_end    = end_out_reg;

    property p_last_restarts;
        @(posedge clk) disable iff (!rst_n)
        (in_fire && last_pixel) |=> (col_reg == '0 && row_reg == '0);
    endproperty
    a_last_restarts: assert property (p_last_restarts)
        else $error("counters not cleared after frame end");

    property p_col_in_frame;
        @(posedge clk) disable iff (!rst_n)
        !restart_reg |-> (col_reg < side_eff && row_reg < side_eff);
    endproperty
    a_col_in_frame: assert property (p_col_in_frame)
        else $error("pixel counter outside the frame");

    property p_no_accept_while_deriving;
        @(posedge clk) disable iff (!rst_n)
        (div_status.busy || restart_reg) |-> !in_fire;
    endproperty
    a_no_accept_while_deriving: assert property (p_no_accept_while_deriving)
        else $error("request accepted while the shift is being derived");

    property p_shift_bounded;
        @(posedge clk) disable iff (!rst_n)
        !busy |-> (shift_reg <= init_shift_reg);
    endproperty
    a_shift_bounded: assert property (p_shift_bounded)
        else $error("row shift above its starting value");

endmodule
